// ===== rtl/ssm_pkg.sv =====
// Shared types, constants and a helper function of the subpixel stripe magnifier.
package ssm_pkg;

    localparam int SRC_MAX = 4096;

    localparam logic [23:0] MASK_BLUE  = 24'h0000FF;
    localparam logic [23:0] MASK_RED   = 24'hFF0000;
    localparam logic [23:0] MASK_GREEN = 24'h00FF00;

    typedef enum logic [2:0] {
        REG_SCALE,
        REG_BGR_ORDER,
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_DEST_WIDTH,
        REG_DEST_HEIGHT,
        REG_SRC_WIDTH,
        REG_SRC_HEIGHT
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLIP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic clip;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic clip_empty;
        logic emit_last;
        logic out_free;
    } status_t;

    // Floor of v / 3 for v below 128, as a multiply by 43 and a shift by 7.
    function automatic logic [6:0] div3(input logic [6:0] v);
        logic [13:0] prod;
        prod = 14'(v) * 14'd43;
        return prod[13:7];
    endfunction

endpackage

// ===== rtl/ssm_ctrl.sv =====
// Controller state machine of the subpixel stripe magnifier.
module ssm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ssm_pkg::status_t  status,
    output ssm_pkg::cmd_t     cmd
);

    ssm_pkg::state_t state_reg;
    ssm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ssm_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ssm_pkg::ST_CLIP;
                end
            end
            ssm_pkg::ST_CLIP:
            begin
                cmd.clip = 1'b1;
                if (status.clip_empty)
                begin
                    state_next = ssm_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = ssm_pkg::ST_EMIT;
                end
            end
            ssm_pkg::ST_EMIT:
            begin
                cmd.emit = status.out_free;
                if (status.out_free && status.emit_last)
                begin
                    state_next = ssm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ssm_datapath.sv =====
// Datapath of the subpixel stripe magnifier: counters, clipping and pixel output register.
module ssm_datapath #(
    parameter int SCW = 6,
    parameter int DW  = 14,
    parameter int DXW = 13,
    parameter int XW  = 19
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ssm_pkg::cmd_t       cmd,
    output ssm_pkg::status_t    status,
    input  logic [SCW-1:0]      sc,
    input  logic                bgr_order,
    input  logic signed [13:0]  origin_x,
    input  logic signed [13:0]  origin_y,
    input  logic [DW-1:0]       dw,
    input  logic [DW-1:0]       dh,
    input  logic [12:0]         sw,
    input  logic [12:0]         sh,
    input  logic [31:0]         color,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [23:0]         pixel,
    output logic [DXW-1:0]      dest_x,
    output logic [DXW-1:0]      first_row,
    output logic [SCW-1:0]      row_count,
    output logic                last
);

    localparam int PW = 12 + SCW;

    logic [11:0]           src_col_reg;
    logic [11:0]           src_row_reg;
    logic signed [XW-1:0]  run_x_reg;
    logic signed [XW-1:0]  base_x_reg;
    logic [PW-1:0]         prod_reg;
    logic [23:0]           color_reg;
    logic [SCW-1:0]        i_reg;
    logic [SCW-1:0]        i_hi_reg;
    logic [SCW-1:0]        s1_reg;
    logic [SCW-1:0]        s2_reg;
    logic [SCW-1:0]        s3_reg;
    logic [DXW-1:0]        row0_reg;
    logic [SCW-1:0]        rows_reg;
    logic                  out_valid_reg;
    logic [23:0]           pixel_reg;
    logic [DXW-1:0]        dest_x_reg;
    logic [DXW-1:0]        first_row_reg;
    logic [SCW-1:0]        row_count_reg;
    logic                  last_reg;

    logic signed [XW-1:0]  sc_ext;
    logic signed [XW-1:0]  ox_ext;
    logic signed [XW-1:0]  oy_ext;
    logic signed [XW-1:0]  base_x;
    logic [12:0]           col_inc;
    logic [12:0]           row_inc;
    logic signed [XW-1:0]  min_y;
    logic signed [XW-1:0]  lim_y;
    logic signed [XW-1:0]  y_lo;
    logic signed [XW-1:0]  y_hi;
    logic signed [XW-1:0]  i_lo_w;
    logic signed [XW-1:0]  i_lo_c;
    logic signed [XW-1:0]  room;
    logic signed [XW-1:0]  i_hi_w;
    logic signed [XW-1:0]  i_hi_c;
    logic signed [XW-1:0]  rows_w;
    logic signed [XW-1:0]  x_w;
    logic [SCW-1:0]        stripe;
    logic [SCW:0]          i_inc;
    logic [23:0]           mask_l;
    logic [23:0]           mask_r;
    logic [23:0]           px;

    assign sc_ext = $signed(XW'(sc));
    assign ox_ext = XW'(origin_x);
    assign oy_ext = XW'(origin_y);
    assign base_x = (src_col_reg == '0) ? ox_ext : run_x_reg;
    assign col_inc = {1'b0, src_col_reg} + 13'd1;
    assign row_inc = {1'b0, src_row_reg} + 13'd1;

    // Vertical extent of the source row, clipped to the bitmap.
    assign min_y = $signed(XW'(prod_reg)) + oy_ext;
    assign lim_y = min_y + sc_ext;
    assign y_lo  = (min_y < 0) ? '0 : min_y;
    assign y_hi  = (lim_y > $signed(XW'(dh))) ? $signed(XW'(dh)) : lim_y;
    assign rows_w = y_hi - y_lo;

    // Horizontal run of visible offsets within the source pixel.
    assign i_lo_w = (base_x_reg < 0) ? -base_x_reg : '0;
    assign i_lo_c = (i_lo_w > sc_ext) ? sc_ext : i_lo_w;
    assign room   = $signed(XW'(dw)) - base_x_reg;
    assign i_hi_w = (room > sc_ext) ? sc_ext : room;
    assign i_hi_c = (i_hi_w < 0) ? '0 : i_hi_w;

    assign stripe = SCW'(ssm_pkg::div3(7'(sc)));

    assign status.clip_empty = !(y_lo < y_hi) || !(i_lo_c < i_hi_c);
    assign i_inc             = {1'b0, i_reg} + {{SCW{1'b0}}, 1'b1};
    assign status.emit_last  = (i_inc == {1'b0, i_hi_reg});
    assign status.out_free   = !out_valid_reg || out_ready;

    assign mask_l = bgr_order ? ssm_pkg::MASK_BLUE : ssm_pkg::MASK_RED;
    assign mask_r = bgr_order ? ssm_pkg::MASK_RED : ssm_pkg::MASK_BLUE;
    assign x_w    = base_x_reg + $signed(XW'(i_reg));

    always_comb
    begin
        if (i_reg < s1_reg)
        begin
            px = color_reg & mask_l;
        end
        else if (i_reg < s2_reg)
        begin
            px = color_reg & ssm_pkg::MASK_GREEN;
        end
        else if (i_reg < s3_reg)
        begin
            px = color_reg & mask_r;
        end
        else
        begin
            px = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            run_x_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                run_x_reg <= base_x + sc_ext;
                if (col_inc >= sw)
                begin
                    src_col_reg <= '0;
                    src_row_reg <= (row_inc >= sh) ? '0 : row_inc[11:0];
                end
                else
                begin
                    src_col_reg <= col_inc[11:0];
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            base_x_reg <= base_x;
            color_reg  <= color[23:0];
            prod_reg   <= PW'(src_row_reg) * PW'(sc);
        end
        if (cmd.clip)
        begin
            i_reg    <= i_lo_c[SCW-1:0];
            i_hi_reg <= i_hi_c[SCW-1:0];
            row0_reg <= y_lo[DXW-1:0];
            rows_reg <= rows_w[SCW-1:0];
            s1_reg   <= stripe;
            s2_reg   <= stripe + stripe;
            s3_reg   <= stripe + stripe + stripe;
        end
        else if (cmd.emit)
        begin
            i_reg <= i_inc[SCW-1:0];
        end
        if (cmd.emit)
        begin
            pixel_reg     <= px;
            dest_x_reg    <= x_w[DXW-1:0];
            first_row_reg <= row0_reg;
            row_count_reg <= rows_reg;
            last_reg      <= status.emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel     = pixel_reg;
    assign dest_x    = dest_x_reg;
    assign first_row = first_row_reg;
    assign row_count = row_count_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/subpixel_stripe_magnifier_unit.sv =====
// Top level of the subpixel stripe magnifier: register file, controller and datapath.
// Each accepted source pixel passes the accept state and the clip state, then the emit state
// sends one beat per visible destination pixel while the output is free.
// A fully clipped source pixel goes from the clip state straight back to idle.
// The first result beat is registered in the emit state, once the output is free.
// Asynchronous active-low reset returns the registers to their defaults and the counters to zero.
module subpixel_stripe_magnifier_unit #(
    parameter int MAX_SCALE    = 32,
    parameter int MAX_DEST_DIM = 8192
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_index,
    input  logic [13:0]                       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [31:0]                       color,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [23:0]                       pixel,
    output logic [$clog2(MAX_DEST_DIM)-1:0]   dest_x,
    output logic [$clog2(MAX_DEST_DIM)-1:0]   first_row,
    output logic [$clog2(MAX_SCALE+1)-1:0]    row_count,
    output logic                              last
);

    // Width of the effective scale and of per-pixel offsets and row counts.
    localparam int SCW = $clog2(MAX_SCALE + 1);
    // Width of a saturated destination dimension.
    localparam int DW  = $clog2(MAX_DEST_DIM + 1);
    // Width of an output coordinate.
    localparam int DXW = $clog2(MAX_DEST_DIM);
    // Signed width that covers every intermediate coordinate of a frame.
    localparam int XW  = $clog2(ssm_pkg::SRC_MAX * MAX_SCALE + MAX_DEST_DIM + 8193) + 1;

    // Configuration registers, written one at a time through the plain write port.
    logic [5:0]         scale_reg;
    logic               bgr_order_reg;
    logic signed [13:0] origin_x_reg;
    logic signed [13:0] origin_y_reg;
    logic [13:0]        dest_width_reg;
    logic [13:0]        dest_height_reg;
    logic [12:0]        src_width_reg;
    logic [12:0]        src_height_reg;

    logic [SCW-1:0]     sc_eff;
    logic [DW-1:0]      dw_eff;
    logic [DW-1:0]      dh_eff;
    logic [12:0]        sw_eff;
    logic [12:0]        sh_eff;

    ssm_pkg::cmd_t      cmd;
    ssm_pkg::status_t   status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg       <= 6'd3;
            bgr_order_reg   <= 1'b0;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            dest_width_reg  <= 14'd640;
            dest_height_reg <= 14'd480;
            src_width_reg   <= 13'd64;
            src_height_reg  <= 13'd64;
        end
        else if (cfg_we)
        begin
            case (ssm_pkg::cfg_reg_t'(cfg_index))
                ssm_pkg::REG_SCALE:       scale_reg       <= cfg_data[5:0];
                ssm_pkg::REG_BGR_ORDER:   bgr_order_reg   <= cfg_data[0];
                ssm_pkg::REG_ORIGIN_X:    origin_x_reg    <= $signed(cfg_data);
                ssm_pkg::REG_ORIGIN_Y:    origin_y_reg    <= $signed(cfg_data);
                ssm_pkg::REG_DEST_WIDTH:  dest_width_reg  <= cfg_data;
                ssm_pkg::REG_DEST_HEIGHT: dest_height_reg <= cfg_data;
                ssm_pkg::REG_SRC_WIDTH:   src_width_reg   <= cfg_data[12:0];
                ssm_pkg::REG_SRC_HEIGHT:  src_height_reg  <= cfg_data[12:0];
                default:
                begin
                end
            endcase
        end
    end

    // A scale of zero behaves as one, and anything above the maximum saturates.
    always_comb
    begin
        if (scale_reg == '0)
        begin
            sc_eff = SCW'(1);
        end
        else if (8'(scale_reg) > 8'(MAX_SCALE))
        begin
            sc_eff = SCW'(MAX_SCALE);
        end
        else
        begin
            sc_eff = SCW'(scale_reg);
        end
    end

    // Destination sizes saturate at the maximum; a size of zero clips everything.
    assign dw_eff = (18'(dest_width_reg) > 18'(MAX_DEST_DIM)) ?
                    DW'(MAX_DEST_DIM) : DW'(dest_width_reg);
    assign dh_eff = (18'(dest_height_reg) > 18'(MAX_DEST_DIM)) ?
                    DW'(MAX_DEST_DIM) : DW'(dest_height_reg);

    // Source sizes are held between one and the largest supported frame.
    assign sw_eff = (src_width_reg == '0) ? 13'd1 :
                    (src_width_reg > 13'(ssm_pkg::SRC_MAX)) ? 13'(ssm_pkg::SRC_MAX) :
                    src_width_reg;
    assign sh_eff = (src_height_reg == '0) ? 13'd1 :
                    (src_height_reg > 13'(ssm_pkg::SRC_MAX)) ? 13'(ssm_pkg::SRC_MAX) :
                    src_height_reg;

    // The controller sequences accept, clip and emit; the datapath does the arithmetic.
    ssm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ssm_datapath #(
        .SCW (SCW),
        .DW  (DW),
        .DXW (DXW),
        .XW  (XW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sc        (sc_eff),
        .bgr_order (bgr_order_reg),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .dw        (dw_eff),
        .dh        (dh_eff),
        .sw        (sw_eff),
        .sh        (sh_eff),
        .color     (color),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .pixel     (pixel),
        .dest_x    (dest_x),
        .first_row (first_row),
        .row_count (row_count),
        .last      (last)
    );

endmodule

// ===== rtl/ssm_checker.sv =====
// Port-level assertions for the subpixel stripe magnifier, bound to the top level.
module ssm_checker #(
    parameter int MAX_SCALE    = 32,
    parameter int MAX_DEST_DIM = 8192
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [23:0]                       pixel,
    input logic [$clog2(MAX_DEST_DIM)-1:0]   dest_x,
    input logic [$clog2(MAX_DEST_DIM)-1:0]   first_row,
    input logic [$clog2(MAX_SCALE+1)-1:0]    row_count,
    input logic                              last
);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel) && $stable(dest_x)
            && $stable(first_row) && $stable(row_count) && $stable(last))
        else $error("result beat changed while stalled");

    // One source pixel is worked on at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while previous item still clipping");

    // Until the last beat of a source pixel is loaded, no new pixel is taken.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input ready in the middle of a source pixel");

    // A taken beat that is not the last is followed at once by the next one.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("gap inside the beats of one source pixel");

    // Every emitted pixel covers at least one row.
    a_rows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> row_count != '0)
        else $error("result beat with zero row count");

endmodule

bind subpixel_stripe_magnifier_unit ssm_checker #(
    .MAX_SCALE    (MAX_SCALE),
    .MAX_DEST_DIM (MAX_DEST_DIM)
) u_ssm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel     (pixel),
    .dest_x    (dest_x),
    .first_row (first_row),
    .row_count (row_count),
    .last      (last)
);

// ===== test/subpixel_stripe_magnifier_unit_tb.sv =====
// Self-checking testbench of the subpixel stripe magnifier: stimulus, prediction and checking.
`timescale 1ns / 100ps

// Limits of the block as configured in this bench (the default parameters of the top level).
localparam int SCALE_CAP = 32;
localparam int DEST_CAP  = 8192;

// One destination pixel as it leaves the block on the output channel.
typedef struct packed {
    logic [23:0] pixel;
    logic [12:0] dest_x;
    logic [12:0] first_row;
    logic [5:0]  row_count;
    logic        last;
} dest_pixel_t;

// Predicts the destination pixels of every accepted source pixel and checks
// the beats that come out of the block against them, oldest first.
class stripe_model;
    logic [5:0]  scale_reg;
    logic        bgr_reg;
    int          origin_x_reg;
    int          origin_y_reg;
    int          dest_w_reg;
    int          dest_h_reg;
    int          src_w_reg;
    int          src_h_reg;
    int          col;
    int          row;
    int          run_x;
    dest_pixel_t dest_pixels[$];
    int          errors;

    function new();
        scale_reg    = 6'd3;
        bgr_reg      = 1'b0;
        origin_x_reg = 0;
        origin_y_reg = 0;
        dest_w_reg   = 640;
        dest_h_reg   = 480;
        src_w_reg    = 64;
        src_h_reg    = 64;
        col          = 0;
        row          = 0;
        run_x        = 0;
        errors       = 0;
    endfunction

    function void write_reg(ssm_pkg::cfg_reg_t idx, logic [13:0] data);
        case (idx)
            ssm_pkg::REG_SCALE:       scale_reg    = data[5:0];
            ssm_pkg::REG_BGR_ORDER:   bgr_reg      = data[0];
            ssm_pkg::REG_ORIGIN_X:    origin_x_reg = $signed(data);
            ssm_pkg::REG_ORIGIN_Y:    origin_y_reg = $signed(data);
            ssm_pkg::REG_DEST_WIDTH:  dest_w_reg   = data;
            ssm_pkg::REG_DEST_HEIGHT: dest_h_reg   = data;
            ssm_pkg::REG_SRC_WIDTH:   src_w_reg    = data[12:0];
            ssm_pkg::REG_SRC_HEIGHT:  src_h_reg    = data[12:0];
            default:                  ;
        endcase
    endfunction

    // Expands one source pixel into its visible destination pixels.
    function void magnify(logic [31:0] color);
        int          sc;
        int          third;
        int          sw;
        int          sh;
        int          dw;
        int          dh;
        int          x;
        int          y_top;
        int          y_end;
        logic [23:0] mask_l;
        logic [23:0] mask_r;
        logic [23:0] px;
        dest_pixel_t held;
        bit          have;

        have   = 1'b0;
        held   = '0;
        sc     = (scale_reg == 0) ? 1 : ((scale_reg > SCALE_CAP) ? SCALE_CAP : scale_reg);
        third  = sc / 3;
        sw     = (src_w_reg == 0) ? 1 :
                 ((src_w_reg > ssm_pkg::SRC_MAX) ? ssm_pkg::SRC_MAX : src_w_reg);
        sh     = (src_h_reg == 0) ? 1 :
                 ((src_h_reg > ssm_pkg::SRC_MAX) ? ssm_pkg::SRC_MAX : src_h_reg);
        dw     = (dest_w_reg > DEST_CAP) ? DEST_CAP : dest_w_reg;
        dh     = (dest_h_reg > DEST_CAP) ? DEST_CAP : dest_h_reg;
        mask_l = bgr_reg ? ssm_pkg::MASK_BLUE : ssm_pkg::MASK_RED;
        mask_r = bgr_reg ? ssm_pkg::MASK_RED : ssm_pkg::MASK_BLUE;

        // A new source row restarts the horizontal run at the left edge.
        if (col == 0)
            run_x = origin_x_reg;

        y_top = row * sc + origin_y_reg;
        y_end = y_top + sc;
        if (y_top < 0)
            y_top = 0;
        if (y_end > dh)
            y_end = dh;

        if (y_top < y_end) begin
            for (int i = 0; i < sc; i++) begin
                x = run_x + i;
                if (x >= 0 && x < dw) begin
                    if (i < third)
                        px = color[23:0] & mask_l;
                    else if (i < 2 * third)
                        px = color[23:0] & ssm_pkg::MASK_GREEN;
                    else if (i < 3 * third)
                        px = color[23:0] & mask_r;
                    else
                        px = '0;
                    // Hold each pixel back one step so the final one can be marked.
                    if (have)
                        dest_pixels.push_back(held);
                    held.pixel     = px;
                    held.dest_x    = x[12:0];
                    held.first_row = y_top[12:0];
                    held.row_count = 6'(y_end - y_top);
                    held.last      = 1'b0;
                    have           = 1'b1;
                end
            end
            if (have) begin
                held.last = 1'b1;
                dest_pixels.push_back(held);
            end
        end

        run_x += sc;
        col++;
        if (col >= sw) begin
            col = 0;
            row++;
            if (row >= sh)
                row = 0;
        end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    function void compare_beat(dest_pixel_t got);
        dest_pixel_t want;
        if (dest_pixels.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected beat, expected none, actual pixel %h x %0d row %0d",
                     $time, got.pixel, got.dest_x, got.first_row);
        end else begin
            want = dest_pixels.pop_front();
            check_field("pixel", want.pixel, got.pixel);
            check_field("dest_x", want.dest_x, got.dest_x);
            check_field("first_row", want.first_row, got.first_row);
            check_field("row_count", want.row_count, got.row_count);
            check_field("last", want.last, got.last);
        end
    endfunction
endclass

module subpixel_stripe_magnifier_unit_tb;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 5;
    // A fully clipped pixel passes only the accept and clip states inside the block,
    // so a short pause covers one that is still being worked on.
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 420;
    localparam int LONG_HOLD    = 400;
    localparam int END_WAIT     = 20000;
    // Slowest correct run: about 470 source pixels, 32 beats each, every beat
    // behind the longest receiver stall; the limit allows several times that.
    localparam int LIMIT_NS     = 60_000_000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [13:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [31:0] color     = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [23:0] pixel;
    logic [12:0] dest_x;
    logic [12:0] first_row;
    logic [5:0]  row_count;
    logic        last;

    // Stimulus asks the receiver for its one long hold; the receiver marks it done.
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    // While set, the sender offers a new beat right after each accepted one.
    bit eager     = 1'b0;

    stripe_model model = new();

    subpixel_stripe_magnifier_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .color     (color),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel     (pixel),
        .dest_x    (dest_x),
        .first_row (first_row),
        .row_count (row_count),
        .last      (last)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Writes one register. The write enable is dropped on the next edge, so
    // back-to-back writes never assign it twice in one time step.
    task automatic write_reg(input ssm_pkg::cfg_reg_t idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 14'(value);
        @(posedge clk);
        model.write_reg(idx, 14'(value));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one source pixel after a random gap and returns at the edge that
    // accepts it. Valid stays high across back-to-back beats.
    task automatic send_pixel(input logic [31:0] value);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (eager || pick < 50)
            gap = 0;
        else if (pick < 85)
            gap = $urandom_range(1, 3);
        else if (pick < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        color    <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        model.magnify(value);
    endtask

    // Brings the block to idle: every predicted beat has arrived and any
    // fully clipped pixel still inside has had time to retire.
    task automatic settle();
        in_valid <= 1'b0;
        while (model.dest_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Run limit: a hung handshake or a lost beat ends here.
    initial begin
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    // Receiver: checks every accepted output beat and drives out_ready in
    // segments: long runs of ready, per-cycle coin flips, short stalls, and
    // now and then a long stall. Once, on request, it holds off for a long
    // stretch so the block backs up and stops taking input.
    initial begin
        int          seg_left;
        bit          seg_ready;
        int          pick;
        dest_pixel_t got;
        seg_left  = 0;
        seg_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                got = {pixel, dest_x, first_row, row_count, last};
                model.compare_beat(got);
            end
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                seg_left = 0;
            end else begin
                if (seg_left == 0) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 35) begin
                        seg_ready = 1'b1;
                        seg_left  = $urandom_range(1, 40);
                    end else if (pick < 75) begin
                        seg_ready = $urandom_range(0, 1);
                        seg_left  = 1;
                    end else if (pick < 96) begin
                        seg_ready = 1'b0;
                        seg_left  = $urandom_range(1, 4);
                    end else begin
                        seg_ready = 1'b0;
                        seg_left  = $urandom_range(10, 60);
                    end
                end
                out_ready <= seg_ready;
                seg_left--;
            end
        end
    end

    // Stimulus: a directed pass over the corner cases, then random phases,
    // each with its own register setting, written while the block is idle.
    initial begin
        int sc_eff;
        int sw_eff;
        int sh_eff;
        int span_x;
        int span_y;
        int dw;
        int dh;
        int pick;
        int value;
        int count;
        int sent;
        int waited;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: scale three, red on the left. All-zero, all-one and
        // alternating colors toggle every color bit, including the unused top byte.
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h00FF_0000);
        send_pixel(32'hAA55_AA55);
        settle();

        // Scale zero acts as scale one, which leaves only a gap pixel.
        write_reg(ssm_pkg::REG_SCALE, 0);
        write_reg(ssm_pkg::REG_BGR_ORDER, 1);
        send_pixel(32'h5512_3456);
        send_pixel(32'hFFFF_FFFF);
        settle();

        // Scale above the cap saturates to 32, with the stripes swapped for BGR.
        write_reg(ssm_pkg::REG_SCALE, 63);
        send_pixel(32'h00C3_5A81);
        settle();

        // Scale two: still below three, so no stripes, only gaps.
        write_reg(ssm_pkg::REG_SCALE, 2);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0012_3456);
        settle();

        // A zero-width destination clips everything away.
        write_reg(ssm_pkg::REG_DEST_WIDTH, 0);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0080_8080);
        settle();

        // Zero source size acts as one, so every pixel starts a new row of a
        // one-row frame. Oversized destination saturates to 8192, and the
        // origin sits right at the far corner: two columns and two rows survive.
        write_reg(ssm_pkg::REG_SRC_WIDTH, 0);
        write_reg(ssm_pkg::REG_SRC_HEIGHT, 0);
        write_reg(ssm_pkg::REG_DEST_WIDTH, 16383);
        write_reg(ssm_pkg::REG_DEST_HEIGHT, 16383);
        write_reg(ssm_pkg::REG_ORIGIN_X, 8190);
        write_reg(ssm_pkg::REG_ORIGIN_Y, 8190);
        write_reg(ssm_pkg::REG_SCALE, 5);
        send_pixel(32'h00FF_FFFF);
        send_pixel(32'h0001_0203);
        settle();

        // Far left origin: the whole pixel falls left of the bitmap.
        write_reg(ssm_pkg::REG_SCALE, 32);
        write_reg(ssm_pkg::REG_ORIGIN_X, -8192);
        write_reg(ssm_pkg::REG_ORIGIN_Y, -3);
        send_pixel(32'h00FF_FFFF);
        settle();

        // Partly clipped on the left and on the top.
        write_reg(ssm_pkg::REG_ORIGIN_X, -20);
        send_pixel(32'h0012_34FF);
        settle();

        // Source size above 4096 saturates.
        write_reg(ssm_pkg::REG_SCALE, 7);
        write_reg(ssm_pkg::REG_ORIGIN_X, 0);
        write_reg(ssm_pkg::REG_ORIGIN_Y, 0);
        write_reg(ssm_pkg::REG_SRC_WIDTH, 8191);
        write_reg(ssm_pkg::REG_SRC_HEIGHT, 8191);
        send_pixel(32'h0077_8899);
        settle();

        // Small frame, then the width shrinks while the column counter is past
        // the new width: it wraps after the next pixel.
        write_reg(ssm_pkg::REG_SRC_WIDTH, 5);
        write_reg(ssm_pkg::REG_SRC_HEIGHT, 4);
        repeat (6) send_pixel($urandom);
        settle();
        write_reg(ssm_pkg::REG_SRC_WIDTH, 2);
        repeat (3) send_pixel($urandom);
        settle();

        // Back-pressure phase: a fully visible frame, the sender never pauses,
        // and the receiver takes its long hold so the block fills up.
        write_reg(ssm_pkg::REG_SCALE, 4);
        write_reg(ssm_pkg::REG_BGR_ORDER, 0);
        write_reg(ssm_pkg::REG_DEST_WIDTH, 8192);
        write_reg(ssm_pkg::REG_DEST_HEIGHT, 8192);
        write_reg(ssm_pkg::REG_SRC_WIDTH, 8);
        write_reg(ssm_pkg::REG_SRC_HEIGHT, 8);
        eager    = 1'b1;
        hold_req = 1'b1;
        repeat (40) send_pixel($urandom);
        settle();
        sent = 40;

        // Random phases. Sizes are kept small so frames wrap often, and the
        // destination and origin are placed around the magnified frame so
        // that clipping hits every edge; now and then an extreme is chosen.
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                value = 0;
            else if (pick < 18)
                value = $urandom_range(33, 63);
            else if (pick < 24)
                value = SCALE_CAP;
            else
                value = $urandom_range(1, 12);
            sc_eff = (value == 0) ? 1 : ((value > SCALE_CAP) ? SCALE_CAP : value);
            // Data bits above the scale field must be ignored.
            if ($urandom_range(0, 3) == 0)
                value += 64 * $urandom_range(0, 255);
            write_reg(ssm_pkg::REG_SCALE, value);
            write_reg(ssm_pkg::REG_BGR_ORDER, $urandom_range(0, 16383));

            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                sw_eff = 1;
                write_reg(ssm_pkg::REG_SRC_WIDTH, 0);
            end else if (pick < 10) begin
                sw_eff = 8;
                write_reg(ssm_pkg::REG_SRC_WIDTH, $urandom_range(4096, 8191));
            end else begin
                sw_eff = $urandom_range(1, 8);
                write_reg(ssm_pkg::REG_SRC_WIDTH, sw_eff);
            end
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                sh_eff = 1;
                write_reg(ssm_pkg::REG_SRC_HEIGHT, 0);
            end else if (pick < 10) begin
                sh_eff = 6;
                write_reg(ssm_pkg::REG_SRC_HEIGHT, $urandom_range(4096, 8191));
            end else begin
                sh_eff = $urandom_range(1, 6);
                write_reg(ssm_pkg::REG_SRC_HEIGHT, sh_eff);
            end
            span_x = sc_eff * sw_eff;
            span_y = sc_eff * sh_eff;

            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                dw = 0;
                write_reg(ssm_pkg::REG_DEST_WIDTH, 0);
            end else if (pick < 12) begin
                dw = DEST_CAP;
                write_reg(ssm_pkg::REG_DEST_WIDTH, $urandom_range(DEST_CAP, 16383));
            end else begin
                dw = $urandom_range(1, span_x + 8);
                write_reg(ssm_pkg::REG_DEST_WIDTH, dw);
            end
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                dh = 0;
                write_reg(ssm_pkg::REG_DEST_HEIGHT, 0);
            end else if (pick < 12) begin
                dh = DEST_CAP;
                write_reg(ssm_pkg::REG_DEST_HEIGHT, $urandom_range(DEST_CAP, 16383));
            end else begin
                dh = $urandom_range(1, span_y + 8);
                write_reg(ssm_pkg::REG_DEST_HEIGHT, dh);
            end

            if ($urandom_range(0, 99) < 8)
                write_reg(ssm_pkg::REG_ORIGIN_X, $urandom_range(0, 16383));
            else
                write_reg(ssm_pkg::REG_ORIGIN_X,
                          int'($urandom_range(0, span_x + dw)) - span_x);
            if ($urandom_range(0, 99) < 8)
                write_reg(ssm_pkg::REG_ORIGIN_Y, $urandom_range(0, 16383));
            else
                write_reg(ssm_pkg::REG_ORIGIN_Y,
                          int'($urandom_range(0, span_y + dh)) - span_y);

            eager = ($urandom_range(0, 3) == 0);
            count = $urandom_range(8, 40);
            repeat (count) send_pixel($urandom);
            sent += count;
            if (sent < RANDOM_ITEMS)
                settle();
        end

        // Drain: wait for the outstanding beats, bounded, then a short pause
        // so that any stray beat still shows up as unexpected.
        in_valid <= 1'b0;
        waited = 0;
        while (model.dest_pixels.size() != 0 && waited < END_WAIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (model.dest_pixels.size() != 0) begin
            model.errors++;
            $display("%0t ns: %0d expected beats never arrived, expected none left, actual %0d",
                     $time, model.dest_pixels.size(), model.dest_pixels.size());
        end
        if (model.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== subpixel_stripe_magnifier_unit.f =====
rtl/ssm_pkg.sv
rtl/ssm_ctrl.sv
rtl/ssm_datapath.sv
rtl/subpixel_stripe_magnifier_unit.sv
rtl/ssm_checker.sv
test/subpixel_stripe_magnifier_unit_tb.sv
